// ===== rtl/core/mcmsp_pkg.sv =====
package mcmsp_pkg;

    localparam int GROUP_COUNT = 4;
    localparam int GROUP_W     = 16;
    localparam int SIZE_W      = 7;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int CODE_W      = 2;
    localparam int CURSOR_SIDE_DEF = 64;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 136;

    typedef logic [GROUP_W-1:0] group_word_t;

    localparam group_word_t MASK_IDLE   = 16'hffff;
    localparam group_word_t SOURCE_IDLE = 16'h0000;

    typedef enum logic [1:0] {
        PIX_CLEAR   = 2'd0,
        PIX_BLACK_A = 2'd1,
        PIX_BLACK_B = 2'd2,
        PIX_WHITE   = 2'd3
    } pixel_code_t;

    typedef enum logic {
        REG_CURSOR_WIDTH  = 1'b0,
        REG_CURSOR_HEIGHT = 1'b1
    } reg_index_t;

endpackage

// ===== rtl/core/mono_cursor_mask_source_packer_top.sv =====
// Packs a mono hardware cursor, one 2-bit pixel per item, into 64-pixel rows of four
// 16-pixel mask and source words (pixel 0 of a group at bit 15). A pixel is taken every
// cycle while the output slot can take a row, and a finished row leaves through a single
// output register. After the last supplied row the pixel input stalls while
// the transparent rows up to CURSOR_SIDE-1 go out, one per cycle while the sink takes
// them; the row with number CURSOR_SIDE-1 carries tlast and ends the image. Register
// writes are always taken and act at once; sizes of zero count as one and sizes above
// CURSOR_SIDE are saturated.
module mono_cursor_mask_source_packer_top #(
    parameter int CURSOR_SIDE = mcmsp_pkg::CURSOR_SIDE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] pixel_code, [7:2] zero
    input  logic [mcmsp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [5:0] row_number, [21:6] mask_group_0, [37:22] mask_group_1,
    // [53:38] mask_group_2, [69:54] mask_group_3, [85:70] source_group_0,
    // [101:86] source_group_1, [117:102] source_group_2,
    // [133:118] source_group_3, [135:134] zero
    output logic [mcmsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [mcmsp_pkg::SIZE_W-1:0]         cfg_data
);
    import mcmsp_pkg::*;

    localparam logic [SIZE_W-1:0] SIDE     = SIZE_W'(CURSOR_SIDE);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(CURSOR_SIDE - 1);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    group_word_t       mask_reg [GROUP_COUNT];
    group_word_t       mask_next [GROUP_COUNT];
    group_word_t       src_reg [GROUP_COUNT];
    group_word_t       src_next [GROUP_COUNT];

    logic              pad_active_reg;
    logic              pad_active_next;
    logic [ROW_W-1:0]  pad_row_reg;
    logic [ROW_W-1:0]  pad_row_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [ROW_W-1:0]  out_row_next;
    group_word_t       out_mask_reg [GROUP_COUNT];
    group_word_t       out_mask_next [GROUP_COUNT];
    group_word_t       out_src_reg [GROUP_COUNT];
    group_word_t       out_src_next [GROUP_COUNT];
    logic              out_last_reg;
    logic              out_last_next;

    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic              slot_free;
    logic              in_fire;
    logic              pix_in_row;
    logic              row_end;
    logic              image_end;
    logic [1:0]        grp;
    logic [3:0]        bit_pos;
    pixel_code_t       code;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = SIZE_W'(1);
        else if (width_reg > SIDE)
            width_eff = SIDE;
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = SIZE_W'(1);
        else if (height_reg > SIDE)
            height_eff = SIDE;
        else
            height_eff = height_reg;
    end

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pad_active_reg && slot_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign code       = pixel_code_t'(s_axis_tdata[CODE_W-1:0]);
    assign grp        = col_reg[5:4];
    assign bit_pos    = ~col_reg[3:0];
    assign pix_in_row = {1'b0, col_reg} < width_eff;
    assign row_end    = ({1'b0, col_reg} + SIZE_W'(1)) >= width_eff;
    // Height is saturated to the cursor side, so this also covers the last row.
    assign image_end  = ({1'b0, row_reg} + SIZE_W'(1)) >= height_eff;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        mask_next       = mask_reg;
        src_next        = src_reg;
        pad_active_next = pad_active_reg;
        pad_row_next    = pad_row_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_row_next    = out_row_reg;
        out_mask_next   = out_mask_reg;
        out_src_next    = out_src_reg;
        out_last_next   = out_last_reg;

        if (in_fire)
        begin
            if (pix_in_row)
            begin
                case (code)
                    PIX_BLACK_A, PIX_BLACK_B:
                    begin
                        mask_next[grp][bit_pos] = 1'b0;
                    end
                    PIX_WHITE:
                    begin
                        mask_next[grp][bit_pos] = 1'b0;
                        src_next[grp][bit_pos]  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (!row_end)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                out_valid_next = 1'b1;
                out_row_next   = row_reg;
                out_mask_next  = mask_next;
                out_src_next   = src_next;
                out_last_next  = (row_reg == LAST_ROW);
                col_next       = '0;
                for (int k = 0; k < GROUP_COUNT; k++)
                begin
                    mask_next[k] = MASK_IDLE;
                    src_next[k]  = SOURCE_IDLE;
                end
                if (!image_end)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    row_next = '0;
                    if (row_reg != LAST_ROW)
                    begin
                        pad_active_next = 1'b1;
                        pad_row_next    = row_reg + ROW_W'(1);
                    end
                end
            end
        end
        else if (pad_active_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            out_row_next   = pad_row_reg;
            out_last_next  = (pad_row_reg == LAST_ROW);
            for (int k = 0; k < GROUP_COUNT; k++)
            begin
                out_mask_next[k] = MASK_IDLE;
                out_src_next[k]  = SOURCE_IDLE;
            end
            if (pad_row_reg == LAST_ROW)
                pad_active_next = 1'b0;
            else
                pad_row_next = pad_row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= SIZE_W'(CURSOR_SIDE_DEF);
            height_reg     <= SIZE_W'(CURSOR_SIDE_DEF);
            col_reg        <= '0;
            row_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < GROUP_COUNT; k++)
            begin
                mask_reg[k] <= MASK_IDLE;
                src_reg[k]  <= SOURCE_IDLE;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_CURSOR_WIDTH:  width_reg  <= cfg_data;
                    REG_CURSOR_HEIGHT: height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            mask_reg       <= mask_next;
            src_reg        <= src_next;
            pad_active_reg <= pad_active_next;
            pad_row_reg    <= pad_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_mask_reg <= out_mask_next;
        out_src_reg  <= out_src_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00,
                            out_src_reg[3], out_src_reg[2], out_src_reg[1], out_src_reg[0],
                            out_mask_reg[3], out_mask_reg[2], out_mask_reg[1],
                            out_mask_reg[0], out_row_reg};

    // While transparent rows are going out, no row is being filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        pad_active_reg |-> (col_reg == '0 && row_reg == '0 && mask_reg[0] == MASK_IDLE
                            && src_reg[3] == SOURCE_IDLE))
        else $error("row state not idle during padding");

    // A pixel is never taken while a waiting row would be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !(out_valid_reg && !m_axis_tready))
        else $error("pixel taken while output row is stalled");

    // Transparent rows follow each other in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && pad_active_reg)
        |=> (m_axis_tvalid && out_row_reg == $past(out_row_reg) + ROW_W'(1)))
        else $error("padding row out of order");

endmodule
